// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the ray/quad intersection RTL.
// Depends on nothing; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check prop at every rising clock edge, held off while reset is low
`define RQI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rqi assertion failed");
// check prop at every rising clock edge, reset included
`define RQI_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("rqi assertion failed");
`else
`define RQI_ASSERT(lbl, clk, rst_n, prop)
`define RQI_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hdl/rqi_pkg.sv =====
// Types, constants and helpers of the ray/quad intersection block.
// Used by rqi_divider, ray_quad_intersect_top and its testbench.
package rqi_pkg;

    // coordinate saturation width, clamped to the 32-bit fields
    localparam int COORD_WIDTH = 32;
    localparam int SAT_W = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    // datapath widths
    localparam int DEN_W  = 55;         // |n.dir|, Q.28
    localparam int NUM_W  = 56;         // |D - n.origin|, Q.28
    localparam int REM_W  = 72;         // dividend scaled by 2^16
    localparam int QUO_W  = 32;         // quotient bits, Q16.16
    localparam int WIDE_W = REM_W + QUO_W - 1 > DEN_W + QUO_W ? REM_W + QUO_W : DEN_W + QUO_W;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CORNER = 3'd0,
        CFG_EDGE_U = 3'd1,
        CFG_EDGE_V = 3'd2,
        CFG_NORMAL = 3'd3,
        CFG_OFFSET = 3'd4,
        CFG_W_VEC  = 3'd5,
        CFG_EPS    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] t_min;
        logic signed [31:0] t_max;
    } t_ray;

    typedef struct packed {
        logic               hit_flag;
        logic signed [31:0] hit_t;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic        [16:0] coord_alpha;
        logic        [16:0] coord_beta;
        logic               front_face;
    } t_hit;

    // per-item side data that rides along the division stages
    typedef struct packed {
        t_ray ray;
        logic neg;     // quotient sign
        logic front;   // n.dir < 0
        logic miss;    // parallel ray
        logic ovf;     // quotient beyond 32 bits
    } t_carry;

    // signed Q8.12 component k of a packed vector
    function automatic logic signed [20:0] comp(input logic [62:0] vec, input int k);
        comp = $signed(vec[21*k +: 21]);
    endfunction

    // clamp to the coordinate range
    function automatic logic signed [31:0] sat_coord(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = (x > SAT_HI) ? SAT_HI : ((x < SAT_LO) ? SAT_LO : x);
        sat_coord = y[31:0];
    endfunction

endpackage

// ===== hdl/rqi_divider.sv =====
// Pipelined restoring divider: an input register, then one quotient bit per register stage.
// Depends on rqi_pkg for widths and the carried item data.
module rqi_divider import rqi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  t_carry            i_carry,
    output logic              o_vld,
    output logic [QUO_W-1:0]  o_quo,
    output t_carry            o_carry
);

    localparam int NST = QUO_W + 1;

    logic                r_vld [NST];
    logic [REM_W-1:0]    r_rem [NST];
    logic [DEN_W-1:0]    r_den [NST];
    logic [QUO_W-1:0]    r_quo [NST];
    t_carry              r_cr  [NST];

    // input stage: dividend scaled by 2^16
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
        if (i_en) begin
            r_rem[0] <= {i_num, 16'b0};
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_cr[0]  <= i_carry;
        end
    end

    // one restoring step per stage, quotient bit QUO_W-1 first
    for (genvar k = 1; k < NST; k++) begin : g_step
        localparam int SH = QUO_W - k;
        logic [WIDE_W-1:0] w_sub;
        logic [WIDE_W-1:0] w_rem;
        logic              w_ge;
        logic [REM_W-1:0]  n_rem;
        logic [QUO_W-1:0]  n_quo;

        always_comb begin
            w_sub = WIDE_W'(r_den[k-1]) << SH;
            w_rem = WIDE_W'(r_rem[k-1]);
            w_ge  = (w_rem >= w_sub);
            n_rem = w_ge ? REM_W'(w_rem - w_sub) : r_rem[k-1];
            n_quo = r_quo[k-1];
            n_quo[SH] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= r_den[k-1];
                r_quo[k] <= n_quo;
                r_cr[k]  <= r_cr[k-1];
            end
        end
    end

    assign o_vld   = r_vld[NST-1];
    assign o_quo   = r_quo[NST-1];
    assign o_carry = r_cr[NST-1];

endmodule

// ===== hdl/ray_quad_intersect_top.sv =====
// Ray against parallelogram intersection test, fully pipelined.
// Depends on rqi_pkg, rqi_divider and assert_macros.svh.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  ray      | in        | i_valid / o_stall   | i_ray (t_ray)
//  hit      | out       | o_valid / i_stall   | o_res (t_hit)
//  config   | in        | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// One ray per cycle while i_stall does not hold the output item; the 33-stage divider
// (input register plus one quotient bit per stage) sits between stages A and C.
// Synchronous active-low reset clears all valid bits and the configuration registers, but sets r_eps to 1.
// When the output item waits under i_stall the whole pipeline holds.
module ray_quad_intersect_top import rqi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_ray        i_ray,
    output logic        o_valid,
    input  logic        i_stall,
    output t_hit        o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [62:0] i_cfg_data
);
`include "assert_macros.svh"

    // configuration registers
    logic [62:0]        r_corner, r_eu, r_ev, r_nrm, r_wv;
    logic signed [31:0] r_offs;
    logic [15:0]        r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0;
            r_eu     <= '0;
            r_ev     <= '0;
            r_nrm    <= '0;
            r_offs   <= '0;
            r_wv     <= '0;
            r_eps    <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CORNER: r_corner <= i_cfg_data;
                CFG_EDGE_U: r_eu     <= i_cfg_data;
                CFG_EDGE_V: r_ev     <= i_cfg_data;
                CFG_NORMAL: r_nrm    <= i_cfg_data;
                CFG_OFFSET: r_offs   <= i_cfg_data[31:0];
                CFG_W_VEC:  r_wv     <= i_cfg_data;
                CFG_EPS:    r_eps    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless the output item is held
    logic w_adv;
    logic r_h_vld;
    assign w_adv   = !(r_h_vld && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_h_vld;

    // stage A: normal products with direction and origin
    logic               r_a_vld;
    t_ray               r_a_ray;
    logic signed [52:0] r_a_nd [3];
    logic signed [52:0] r_a_no [3];
    logic signed [31:0] w_o [3];
    logic signed [31:0] w_d [3];

    assign w_o[0] = i_ray.origin_x;
    assign w_o[1] = i_ray.origin_y;
    assign w_o[2] = i_ray.origin_z;
    assign w_d[0] = i_ray.dir_x;
    assign w_d[1] = i_ray.dir_y;
    assign w_d[2] = i_ray.dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_valid;
        end
        if (w_adv) begin
            r_a_ray <= i_ray;
            for (int k = 0; k < 3; k++) begin
                r_a_nd[k] <= 53'(comp(r_nrm, k)) * 53'(w_d[k]);
                r_a_no[k] <= 53'(comp(r_nrm, k)) * 53'(w_o[k]);
            end
        end
    end

    // sums, magnitudes, parallel test, into the divider
    logic signed [DEN_W-1:0] w_den;
    logic signed [NUM_W-1:0] w_num;
    logic [DEN_W-1:0]        w_aden;
    logic [NUM_W-1:0]        w_anum;
    t_carry                  w_cin;

    always_comb begin
        w_den  = DEN_W'(r_a_nd[0]) + DEN_W'(r_a_nd[1]) + DEN_W'(r_a_nd[2]);
        w_num  = (NUM_W'(r_offs) <<< 12)
               - (NUM_W'(r_a_no[0]) + NUM_W'(r_a_no[1]) + NUM_W'(r_a_no[2]));
        w_aden = w_den[DEN_W-1] ? DEN_W'(-w_den) : DEN_W'(w_den);
        w_anum = w_num[NUM_W-1] ? NUM_W'(-w_num) : NUM_W'(w_num);
        w_cin.ray   = r_a_ray;
        w_cin.neg   = w_num[NUM_W-1] ^ w_den[DEN_W-1];
        w_cin.front = w_den[DEN_W-1];
        w_cin.miss  = (w_aden == '0) || (w_aden < DEN_W'({r_eps, 12'b0}));
        // quotient needs more than 32 bits when anum >= aden * 2^16
        w_cin.ovf   = (REM_W'(w_anum) >= REM_W'({w_aden, 16'b0}));
    end

    logic             w_dv_vld;
    logic [QUO_W-1:0] w_quo;
    t_carry           w_dv_cr;

    rqi_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_a_vld),
        .i_num   (w_anum),
        .i_den   (w_aden),
        .i_carry (w_cin),
        .o_vld   (w_dv_vld),
        .o_quo   (w_quo),
        .o_carry (w_dv_cr)
    );

    // stage C: signed, saturated t and interval test
    logic               r_c_vld;
    t_ray               r_c_ray;
    logic               r_c_front, r_c_miss;
    logic signed [31:0] r_c_t;
    logic signed [63:0] w_tc;
    logic signed [31:0] w_t;

    always_comb begin
        w_tc = w_dv_cr.ovf ? (64'sd1 <<< 32) : 64'($unsigned(w_quo));
        if (w_dv_cr.neg) begin
            w_tc = -w_tc;
        end
        w_t = sat_coord(w_tc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_adv) begin
            r_c_vld <= w_dv_vld;
        end
        if (w_adv) begin
            r_c_ray   <= w_dv_cr.ray;
            r_c_front <= w_dv_cr.front;
            r_c_t     <= w_t;
            r_c_miss  <= w_dv_cr.miss || (w_t < w_dv_cr.ray.t_min)
                         || (w_t > w_dv_cr.ray.t_max);
        end
    end

    // stage D: t * dir
    logic               r_d_vld;
    t_ray               r_d_ray;
    logic               r_d_front, r_d_miss;
    logic signed [31:0] r_d_t;
    logic signed [63:0] r_d_td [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_adv) begin
            r_d_vld <= r_c_vld;
        end
        if (w_adv) begin
            r_d_ray   <= r_c_ray;
            r_d_front <= r_c_front;
            r_d_miss  <= r_c_miss;
            r_d_t     <= r_c_t;
            r_d_td[0] <= 64'(r_c_t) * 64'(r_c_ray.dir_x);
            r_d_td[1] <= 64'(r_c_t) * 64'(r_c_ray.dir_y);
            r_d_td[2] <= 64'(r_c_t) * 64'(r_c_ray.dir_z);
        end
    end

    // stage E: hit point and offset from the corner
    logic               r_e_vld, r_e_front, r_e_miss;
    logic signed [31:0] r_e_t;
    logic signed [31:0] r_e_p  [3];
    logic signed [34:0] r_e_hp [3];
    logic signed [31:0] w_po [3];
    logic signed [31:0] w_p  [3];

    assign w_po[0] = r_d_ray.origin_x;
    assign w_po[1] = r_d_ray.origin_y;
    assign w_po[2] = r_d_ray.origin_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_p[k] = sat_coord(64'(w_po[k]) + (r_d_td[k] >>> 16));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_adv) begin
            r_e_vld <= r_d_vld;
        end
        if (w_adv) begin
            r_e_front <= r_d_front;
            r_e_miss  <= r_d_miss;
            r_e_t     <= r_d_t;
            for (int k = 0; k < 3; k++) begin
                r_e_p[k]  <= w_p[k];
                r_e_hp[k] <= 35'(w_p[k]) - (35'(comp(r_corner, k)) <<< 4);
            end
        end
    end

    // stage F: cross product terms, alpha = w.(hp x v), beta = w.(u x hp)
    logic               r_f_vld, r_f_front, r_f_miss;
    logic signed [31:0] r_f_t;
    logic signed [31:0] r_f_p  [3];
    logic signed [55:0] r_f_ap [6];
    logic signed [55:0] r_f_bp [6];

    function automatic logic signed [55:0] mul_c(input logic signed [34:0] a,
                                                 input logic signed [20:0] b);
        mul_c = 56'(a) * 56'(b);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_adv) begin
            r_f_vld <= r_e_vld;
        end
        if (w_adv) begin
            r_f_front <= r_e_front;
            r_f_miss  <= r_e_miss;
            r_f_t     <= r_e_t;
            r_f_p     <= r_e_p;
            // pairs (0,1), (2,3), (4,5) give the x, y, z components
            r_f_ap[0] <= mul_c(r_e_hp[1], comp(r_ev, 2));
            r_f_ap[1] <= mul_c(r_e_hp[2], comp(r_ev, 1));
            r_f_ap[2] <= mul_c(r_e_hp[2], comp(r_ev, 0));
            r_f_ap[3] <= mul_c(r_e_hp[0], comp(r_ev, 2));
            r_f_ap[4] <= mul_c(r_e_hp[0], comp(r_ev, 1));
            r_f_ap[5] <= mul_c(r_e_hp[1], comp(r_ev, 0));
            r_f_bp[0] <= mul_c(r_e_hp[2], comp(r_eu, 1));
            r_f_bp[1] <= mul_c(r_e_hp[1], comp(r_eu, 2));
            r_f_bp[2] <= mul_c(r_e_hp[0], comp(r_eu, 2));
            r_f_bp[3] <= mul_c(r_e_hp[2], comp(r_eu, 0));
            r_f_bp[4] <= mul_c(r_e_hp[1], comp(r_eu, 0));
            r_f_bp[5] <= mul_c(r_e_hp[0], comp(r_eu, 1));
        end
    end

    // stage G: floored cross components times w
    logic               r_g_vld, r_g_front, r_g_miss;
    logic signed [31:0] r_g_t;
    logic signed [31:0] r_g_p  [3];
    logic signed [65:0] r_g_aw [3];
    logic signed [65:0] r_g_bw [3];
    logic signed [56:0] w_ad [3];
    logic signed [56:0] w_bd [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_ad[k] = (57'(r_f_ap[2*k]) - 57'(r_f_ap[2*k+1])) >>> 12;
            w_bd[k] = (57'(r_f_bp[2*k]) - 57'(r_f_bp[2*k+1])) >>> 12;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (w_adv) begin
            r_g_vld <= r_f_vld;
        end
        if (w_adv) begin
            r_g_front <= r_f_front;
            r_g_miss  <= r_f_miss;
            r_g_t     <= r_f_t;
            r_g_p     <= r_f_p;
            for (int k = 0; k < 3; k++) begin
                r_g_aw[k] <= 66'($signed(w_ad[k][44:0])) * 66'(comp(r_wv, k));
                r_g_bw[k] <= 66'($signed(w_bd[k][44:0])) * 66'(comp(r_wv, k));
            end
        end
    end

    // stage H: planar coordinates, bounds, output register
    logic signed [67:0] w_al, w_be;
    logic               w_hit;
    t_hit               n_res, r_res;

    always_comb begin
        w_al  = (68'(r_g_aw[0]) + 68'(r_g_aw[1]) + 68'(r_g_aw[2])) >>> 12;
        w_be  = (68'(r_g_bw[0]) + 68'(r_g_bw[1]) + 68'(r_g_bw[2])) >>> 12;
        w_hit = !r_g_miss && (w_al >= 0) && (w_al <= 68'sd65536)
                && (w_be >= 0) && (w_be <= 68'sd65536);
        n_res = '0;
        if (w_hit) begin
            n_res.hit_flag    = 1'b1;
            n_res.hit_t       = r_g_t;
            n_res.point_x     = r_g_p[0];
            n_res.point_y     = r_g_p[1];
            n_res.point_z     = r_g_p[2];
            n_res.coord_alpha = w_al[16:0];
            n_res.coord_beta  = w_be[16:0];
            n_res.front_face  = r_g_front;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (w_adv) begin
            r_h_vld <= r_g_vld;
        end
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

    // checks
    `RQI_ASSERT(a_stall_only_full, i_clk, i_rst_n, o_stall |-> o_valid)
    `RQI_ASSERT(a_miss_zero, i_clk, i_rst_n, (o_valid && !o_res.hit_flag) |-> (o_res == '0))
    `RQI_ASSERT(a_coord_range, i_clk, i_rst_n, (o_valid && o_res.hit_flag) |-> ((o_res.coord_alpha <= 17'd65536) && (o_res.coord_beta <= 17'd65536)))
    `RQI_ASSERT(a_hold_stall, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_res)))
    `RQI_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

// ===== verif/ray_quad_intersect_top_tb.sv =====
// Testbench for ray_quad_intersect_top: streams rays against several quad setups.
// Checks each hit item against an internal fixed-point predictor; uses rqi_pkg.
module ray_quad_intersect_top_tb import rqi_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // expected hit items, oldest first, with the mismatch tally
    class hit_scoreboard;
        t_hit pending[$];
        int   mismatches;

        function void note_ray(t_hit exp_hit);
            pending.push_back(exp_hit);
        endfunction

        function void check_hit(t_hit got);
            t_hit exp_hit;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected hit item %p", got);
                return;
            end
            exp_hit = pending.pop_front();
            if (got.hit_flag !== exp_hit.hit_flag || got.hit_t !== exp_hit.hit_t ||
                got.point_x !== exp_hit.point_x || got.point_y !== exp_hit.point_y ||
                got.point_z !== exp_hit.point_z || got.coord_alpha !== exp_hit.coord_alpha ||
                got.coord_beta !== exp_hit.coord_beta ||
                got.front_face !== exp_hit.front_face) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: exp %p got %p", exp_hit, got);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_ray        i_ray = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_hit        o_res;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [62:0] i_cfg_data = '0;

    hit_scoreboard sb = new();
    logic [62:0] q_corner, q_u, q_v, q_n, q_w;
    logic [31:0] q_offset;
    logic [15:0] q_eps;
    bit          hold_rx = 0;

    ray_quad_intersect_top u_top (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // floor shift of a signed value
    function automatic longint fshr(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint part(logic [62:0] vec, int k);
        logic signed [20:0] c;
        c = vec[21*k +: 21];
        return longint'(c);
    endfunction

    // w . (a x b), each cross component floored to Q.16 first
    function automatic longint planar_coord(longint a[3], longint b[3]);
        longint c0, c1, c2;
        c0 = fshr(a[1] * b[2] - a[2] * b[1], 12);
        c1 = fshr(a[2] * b[0] - a[0] * b[2], 12);
        c2 = fshr(a[0] * b[1] - a[1] * b[0], 12);
        return fshr(part(q_w, 0) * c0 + part(q_w, 1) * c1 + part(q_w, 2) * c2, 12);
    endfunction

    function automatic t_hit predict_hit(t_ray r);
        t_hit h;
        longint o[3], d[3], hp[3], uu[3], vv[3], p[3];
        longint den, num, t, alpha, beta;
        logic [63:0] anum, aden, qi, rem, frac, mag;
        bit neg;
        h = '0;
        o = '{longint'(r.origin_x), longint'(r.origin_y), longint'(r.origin_z)};
        d = '{longint'(r.dir_x), longint'(r.dir_y), longint'(r.dir_z)};
        den = part(q_n, 0) * d[0] + part(q_n, 1) * d[1] + part(q_n, 2) * d[2];
        aden = den < 0 ? -den : den;
        if (aden == 0 || aden < (64'(q_eps) << 12)) return h;
        num = longint'($signed(q_offset)) * 4096 -
              (part(q_n, 0) * o[0] + part(q_n, 1) * o[1] + part(q_n, 2) * o[2]);
        anum = num < 0 ? -num : num;
        neg = (num < 0) != (den < 0);
        qi = anum / aden;
        rem = anum % aden;
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= aden) begin
                rem = rem - aden;
                frac[0] = 1'b1;
            end
        end
        if (qi >= (64'd1 << 47)) mag = 64'd1 << 62;
        else mag = (qi << 16) | frac;
        if (mag > (64'd1 << 62)) mag = 64'd1 << 62;
        t = clamp32(neg ? -longint'(mag) : longint'(mag));
        if (t < longint'(r.t_min) || t > longint'(r.t_max)) return h;
        for (int i = 0; i < 3; i++) begin
            p[i] = clamp32(o[i] + fshr(t * d[i], 16));
            hp[i] = p[i] - part(q_corner, i) * 16;
            uu[i] = part(q_u, i);
            vv[i] = part(q_v, i);
        end
        alpha = planar_coord(hp, vv);
        beta = planar_coord(uu, hp);
        if (alpha < 0 || alpha > 65536 || beta < 0 || beta > 65536) return h;
        h.hit_flag = 1'b1;
        h.hit_t = t[31:0];
        h.point_x = p[0][31:0];
        h.point_y = p[1][31:0];
        h.point_z = p[2][31:0];
        h.coord_alpha = alpha[16:0];
        h.coord_beta = beta[16:0];
        h.front_face = den < 0;
        return h;
    endfunction

    function automatic logic [62:0] pack_vec(int x, int y, int z);
        return {21'(z), 21'(y), 21'(x)};
    endfunction

    // one register write; i_cfg_we goes low again before the task returns
    task automatic write_reg(t_cfg_idx idx, logic [62:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CORNER: q_corner = val;
            CFG_EDGE_U: q_u = val;
            CFG_EDGE_V: q_v = val;
            CFG_NORMAL: q_n = val;
            CFG_OFFSET: q_offset = val[31:0];
            CFG_W_VEC:  q_w = val;
            default:    q_eps = val[15:0];
        endcase
        @(posedge i_clk);
    endtask

    // axis quad: corner (c,c,h) in Q8.12, edges along x and y with length s
    task automatic set_quad(int c, int h, int s, bit flip, logic [15:0] eps);
        int nz, wz;
        nz = flip ? -4096 : 4096;
        wz = nz;
        write_reg(CFG_CORNER, pack_vec(c, c, h));
        write_reg(CFG_EDGE_U, pack_vec(s, 0, 0));
        write_reg(CFG_EDGE_V, pack_vec(0, s, 0));
        write_reg(CFG_NORMAL, pack_vec(0, 0, nz));
        write_reg(CFG_OFFSET, 63'(32'(nz * h / 4096 * 16)));
        write_reg(CFG_W_VEC, pack_vec(0, 0, (wz * 4096 / s) / 4096 * 4096 / s * s / 4096));
        write_reg(CFG_EPS, 63'(eps));
    endtask

    task automatic send_ray(t_ray r);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ray <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_ray(predict_hit(r));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    // aimed ray: most hit near the quad; rest random bits
    function automatic t_ray aimed_ray(int c, int h, int s);
        t_ray r;
        int span;
        span = s * 24;
        r.origin_x = c * 16 + $urandom_range(0, span) - s * 2;
        r.origin_y = c * 16 + $urandom_range(0, span) - s * 2;
        r.origin_z = h * 16 + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 1 << 20);
        r.dir_x = $signed($urandom_range(0, 1 << 15)) - (1 << 14);
        r.dir_y = $signed($urandom_range(0, 1 << 15)) - (1 << 14);
        r.dir_z = (r.origin_z > h * 16 ? -1 : 1) * $signed($urandom_range(1 << 12, 1 << 17));
        r.t_min = $urandom_range(0, 7) == 0 ? $urandom : 0;
        r.t_max = $urandom_range(0, 7) == 0 ? $urandom : 32'h7fffffff;
        if ($urandom_range(0, 9) == 0) begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom};
        end
        return r;
    endfunction

    // receiver: random stalls, one long hold-off
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                i_stall <= 1'b1;
                repeat (200) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_rx = 0;
            end else if ($urandom_range(0, 5) == 0) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_hit(o_res);
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_ray r;
        q_corner = '0; q_u = '0; q_v = '0; q_n = '0; q_w = '0; q_offset = '0; q_eps = 16'd1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset setup (all rays parallel), then a unit quad
        r = '0;
        r.dir_z = 32'sh10000;
        send_ray(r);
        r = {8{32'h7fffffff}};
        send_ray(r);
        r = {8{32'h80000000}};
        send_ray(r);
        drain();
        set_quad(0, 0, 4096, 0, 16'd0);
        // straight down through center: hit, front face
        r = '0;
        r.origin_x = 32'sh8000; r.origin_y = 32'sh8000; r.origin_z = 32'sh10000;
        r.dir_z = -32'sh10000; r.t_max = 32'h7fffffff;
        send_ray(r);
        r.dir_z = 32'sh10000; r.origin_z = -32'sh10000;  // back face
        send_ray(r);
        r.origin_x = 0; r.origin_y = 0;                 // corner, bounds inclusive
        send_ray(r);
        r.origin_x = 32'sh10000; r.origin_y = 32'sh10000;
        send_ray(r);
        r.origin_x = 32'sh10001;                        // just outside
        send_ray(r);
        r.t_min = 32'sh10000; r.t_max = 32'sh10000;     // exact interval edge
        send_ray(r);
        r.t_min = 32'sh20000; r.t_max = 32'sh10000;     // inverted interval
        send_ray(r);
        r.t_min = 0; r.t_max = 32'h7fffffff;
        r.dir_z = 0; r.dir_x = 32'sh10000;              // exactly parallel, eps 0
        send_ray(r);
        r.dir_x = 0; r.dir_z = 1;                       // tiny denominator: quotient saturates
        r.origin_z = -32'sh7fff0000;
        send_ray(r);
        r.dir_z = 32'h7fffffff; r.dir_x = 32'h80000000; // extreme direction
        send_ray(r);
        drain();

        // random phases over several setups, extremes of eps among them
        for (int ph = 0; ph < 6; ph++) begin
            int c, h, s;
            c = $signed($urandom_range(0, 1 << 16)) - (1 << 15);
            h = $signed($urandom_range(0, 1 << 16)) - (1 << 15);
            s = 1 << $urandom_range(10, 15);
            set_quad(c, h, s, ph[0], ph == 5 ? 16'hffff : (ph == 2 ? 16'd0 : 16'($urandom)));
            if (ph == 3) begin
                write_reg(CFG_NORMAL, 63'({$urandom, $urandom}));
                write_reg(CFG_W_VEC, 63'({$urandom, $urandom}));
                write_reg(CFG_OFFSET, 63'($urandom));
            end
            if (ph == 4) hold_rx = 1;
            for (int k = 0; k < 190; k++) send_ray(aimed_ray(c, h, s));
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
